>>> rtl/clock_buffer_pool_manager_unit_assert.svh
// Assertion macros shared by the buffer pool manager RTL.
// Needs only a clock and an active-low reset in scope at the point of use.
`ifndef CLOCK_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH
`define CLOCK_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CBPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbpm assertion failed");

// antecedent implies consequent in the next cycle
`define CBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbpm assertion failed");

`endif

>>> rtl/cbpm_pkg.sv
// Package for the clock buffer pool manager: sizes, opcodes, result kinds,
// frame metadata type. Used by the top level of the block.
`timescale 1ns / 1ps
package cbpm_pkg;
    localparam int NUM_FRAMES = 32;
    localparam int PAGE_BITS  = 32;
    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FRAME_W    = 5;
    localparam int PAGE_W     = 32;
    localparam int PIN_MAX    = 255;

    localparam logic [2:0] OP_PIN       = 3'd0;
    localparam logic [2:0] OP_PIN_NEW   = 3'd1;
    localparam logic [2:0] OP_UNPIN     = 3'd2;
    localparam logic [2:0] OP_FLUSH     = 3'd3;
    localparam logic [2:0] OP_FLUSH_ALL = 3'd4;

    localparam logic [2:0] K_REPLY   = 3'd0;
    localparam logic [2:0] K_WRITE   = 3'd1;
    localparam logic [2:0] K_READ    = 3'd2;
    localparam logic [2:0] K_ZERO    = 3'd3;
    localparam logic [2:0] K_SYNC    = 3'd4;
    localparam logic [2:0] K_DONE    = 3'd5;
    localparam logic [2:0] K_EXHAUST = 3'd6;

    typedef struct packed {
        logic       valid;
        logic       dirty;
        logic       hot;
        logic [7:0] pin;
    } t_meta;

    localparam int META_W = $bits(t_meta);
endpackage

>>> rtl/cbpm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module cbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/clock_buffer_pool_manager_unit.sv
// Top level of the clock buffer pool manager: request sequencer around
// two frame RAMs (tags, metadata). Depends on cbpm_pkg, cbpm_ram, assert header.
//
// Usage: drive opcode, page, frame and made_dirty with start while busy is low;
// the request is taken at that edge and busy rises. Results come out one per
// strobe cycle on o_valid with kind, frame_index, page_number, hit; o_last
// marks the final result of the request, and busy is already low in that cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Each frame visit is a RAM read state then an evaluate/write-back state, so
// the next read of any entry always follows the write of the last one.
// A pin scans the tag RAM from entry 0 until a hit; on a miss it then steps the
// clock hand (at most 2*NUM_FRAMES steps) to a victim, or reports exhaustion
// when no frame is unpinned. Unpin/flush visit one frame, flush all visits each;
// an unknown opcode goes straight to its done result.
// Throughput: one request at a time; the next start is taken as early as the
// cycle that shows the last result of the previous one.
// Reset clears the hand, the sequencer and the per-frame written bits; a
// metadata entry never written reads as all zero. Tags need no reset.
`timescale 1ns / 1ps
`include "clock_buffer_pool_manager_unit_assert.svh"
module clock_buffer_pool_manager_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_opcode,
    input  logic [cbpm_pkg::PAGE_W-1:0] i_page,
    input  logic [cbpm_pkg::FRAME_W-1:0] i_frame,
    input  logic                        i_made_dirty,
    output logic                        o_valid,
    output logic [2:0]                  o_kind,
    output logic [cbpm_pkg::FRAME_W-1:0] o_frame_index,
    output logic [cbpm_pkg::PAGE_W-1:0] o_page_number,
    output logic                        o_hit,
    output logic                        o_last
);
    import cbpm_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_HIT_RD = 14'b00000000000010,
        S_HIT_EV = 14'b00000000000100,
        S_SWP_RD = 14'b00000000001000,
        S_SWP_EV = 14'b00000000010000,
        S_ONE_RD = 14'b00000000100000,
        S_ONE_EV = 14'b00000001000000,
        S_ALL_RD = 14'b00000010000000,
        S_ALL_EV = 14'b00000100000000,
        S_FILL   = 14'b00001000000000,
        S_ZERO   = 14'b00010000000000,
        S_REPLY  = 14'b00100000000000,
        S_DONE   = 14'b01000000000000,
        S_SYNC   = 14'b10000000000000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
    localparam logic [IDX_W:0]   NF       = (IDX_W + 1)'(NUM_FRAMES);
    localparam logic [FRAME_W:0] NF_FR    = (FRAME_W + 1)'(NUM_FRAMES);

    t_state r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic [FRAME_W-1:0]   r_fr, n_fr;
    logic                 r_md, n_md;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_hand, n_hand;
    logic [IDX_W-1:0]     r_vic, n_vic;
    logic                 r_hitf, n_hitf;
    logic                 r_free, n_free;
    logic [NUM_FRAMES-1:0] r_wr;
    logic                 r_meta_ok;

    logic                 r_valid, n_valid;
    logic [2:0]           r_kind, n_kind;
    logic [FRAME_W-1:0]   r_fi, n_fi;
    logic [PAGE_W-1:0]    r_pn, n_pn;
    logic                 r_hit_o, n_hit_o;
    logic                 r_last, n_last;

    logic [IDX_W-1:0]     raddr;
    logic                 meta_we, tag_we;
    logic [IDX_W-1:0]     meta_waddr;
    t_meta                meta_wdata;
    logic [META_W-1:0]    meta_rd;
    logic [PAGE_BITS-1:0] tag_rd;
    t_meta                m;

    cbpm_ram #(.WIDTH(PAGE_BITS), .DEPTH(NUM_FRAMES), .AW(IDX_W)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(r_vic), .i_wdata(r_page),
        .i_raddr(raddr), .o_rdata(tag_rd)
    );

    cbpm_ram #(.WIDTH(META_W), .DEPTH(NUM_FRAMES), .AW(IDX_W)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(raddr), .o_rdata(meta_rd)
    );

    assign m = r_meta_ok ? t_meta'(meta_rd) : t_meta'('0);

    always_comb begin
        logic [IDX_W:0] h2;
        logic [7:0]     pin_inc;
        h2      = {1'b0, r_hand} + (IDX_W + 1)'(2);
        if (h2 >= NF) h2 = h2 - NF;
        if (h2 >= NF) h2 = h2 - NF;
        pin_inc = (m.pin < 8'(PIN_MAX)) ? m.pin + 8'd1 : m.pin;

        n_state = r_state;
        n_op    = r_op;
        n_page  = r_page;
        n_fr    = r_fr;
        n_md    = r_md;
        n_idx   = r_idx;
        n_hand  = r_hand;
        n_vic   = r_vic;
        n_hitf  = r_hitf;
        n_free  = r_free;
        n_valid = 1'b0;
        n_kind  = r_kind;
        n_fi    = r_fi;
        n_pn    = r_pn;
        n_hit_o = 1'b0;
        n_last  = 1'b0;
        raddr      = r_idx;
        meta_we    = 1'b0;
        tag_we     = 1'b0;
        meta_waddr = r_idx;
        meta_wdata = m;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_opcode;
                    n_page = PAGE_BITS'(i_page);
                    n_fr   = i_frame;
                    n_md   = i_made_dirty;
                    n_idx  = '0;
                    n_free = 1'b0;
                    n_hitf = 1'b0;
                    case (i_opcode)
                        OP_PIN, OP_PIN_NEW: n_state = S_HIT_RD;
                        OP_UNPIN, OP_FLUSH: begin
                            n_idx   = IDX_W'(i_frame);
                            n_state = ({1'b0, i_frame} < NF_FR) ? S_ONE_RD : S_DONE;
                        end
                        OP_FLUSH_ALL: n_state = S_ALL_RD;
                        default: begin
                            n_fr    = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HIT_RD: n_state = S_HIT_EV;
            S_HIT_EV: begin
                n_free = r_free | (m.pin == 8'd0);
                if (m.valid && tag_rd == r_page) begin
                    meta_we    = 1'b1;
                    meta_wdata = '{valid: 1'b1, dirty: m.dirty | (r_op == OP_PIN_NEW),
                                   hot: 1'b1, pin: pin_inc};
                    n_vic   = r_idx;
                    n_hitf  = 1'b1;
                    n_state = (r_op == OP_PIN_NEW) ? S_ZERO : S_REPLY;
                end else if (r_idx == LAST_IDX) begin
                    if (!n_free) begin
                        n_hand  = IDX_W'(h2);
                        n_valid = 1'b1;
                        n_kind  = K_EXHAUST;
                        n_fi    = '0;
                        n_pn    = PAGE_W'(r_page);
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SWP_RD;
                    end
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_HIT_RD;
                end
            end
            S_SWP_RD: begin
                raddr   = r_hand;
                n_state = S_SWP_EV;
            end
            S_SWP_EV: begin
                meta_waddr = r_hand;
                n_hand     = (r_hand == LAST_IDX) ? '0 : r_hand + IDX_W'(1);
                n_state    = S_SWP_RD;
                if (!m.valid) begin
                    n_vic   = r_hand;
                    n_state = S_FILL;
                end else if (m.pin == 8'd0) begin
                    if (!m.hot) begin
                        if (m.dirty) begin
                            n_valid = 1'b1;
                            n_kind  = K_WRITE;
                            n_fi    = FRAME_W'(r_hand);
                            n_pn    = PAGE_W'(tag_rd);
                        end
                        n_vic   = r_hand;
                        n_state = S_FILL;
                    end else begin
                        // second chance: clear hot and move on
                        meta_we    = 1'b1;
                        meta_wdata = '{valid: m.valid, dirty: m.dirty, hot: 1'b0, pin: m.pin};
                    end
                end
            end
            S_FILL: begin
                tag_we     = 1'b1;
                meta_we    = 1'b1;
                meta_waddr = r_vic;
                meta_wdata = '{valid: 1'b1, dirty: (r_op == OP_PIN_NEW), hot: 1'b1,
                               pin: 8'd1};
                n_valid = 1'b1;
                n_kind  = K_READ;
                n_fi    = FRAME_W'(r_vic);
                n_pn    = PAGE_W'(r_page);
                n_state = (r_op == OP_PIN_NEW) ? S_ZERO : S_REPLY;
            end
            S_ZERO: begin
                n_valid = 1'b1;
                n_kind  = K_ZERO;
                n_fi    = FRAME_W'(r_vic);
                n_pn    = PAGE_W'(r_page);
                n_state = S_REPLY;
            end
            S_REPLY: begin
                n_valid = 1'b1;
                n_kind  = K_REPLY;
                n_fi    = FRAME_W'(r_vic);
                n_pn    = PAGE_W'(r_page);
                n_hit_o = r_hitf;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            S_ONE_RD: n_state = S_ONE_EV;
            S_ONE_EV: begin
                n_state = S_DONE;
                if (r_op == OP_UNPIN) begin
                    meta_we    = 1'b1;
                    meta_wdata = '{valid: m.valid, dirty: m.dirty | r_md, hot: m.hot,
                                   pin: (m.pin != 8'd0) ? m.pin - 8'd1 : m.pin};
                end else if (m.valid && m.dirty) begin
                    meta_we    = 1'b1;
                    meta_wdata = '{valid: m.valid, dirty: 1'b0, hot: m.hot, pin: m.pin};
                    n_valid    = 1'b1;
                    n_kind     = K_WRITE;
                    n_fi       = r_fr;
                    n_pn       = PAGE_W'(tag_rd);
                end
            end
            S_ALL_RD: n_state = S_ALL_EV;
            S_ALL_EV: begin
                if (m.valid && m.dirty) begin
                    meta_we    = 1'b1;
                    meta_wdata = '{valid: m.valid, dirty: 1'b0, hot: m.hot, pin: m.pin};
                    n_valid    = 1'b1;
                    n_kind     = K_WRITE;
                    n_fi       = FRAME_W'(r_idx);
                    n_pn       = PAGE_W'(tag_rd);
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_SYNC;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_ALL_RD;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_kind  = K_DONE;
                n_fi    = r_fr;
                n_pn    = '0;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            S_SYNC: begin
                n_valid = 1'b1;
                n_kind  = K_SYNC;
                n_fi    = '0;
                n_pn    = '0;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hand    <= '0;
            r_wr      <= '0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
            r_hit_o   <= 1'b0;
            r_meta_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hand    <= n_hand;
            r_valid   <= n_valid;
            r_last    <= n_last;
            r_hit_o   <= n_hit_o;
            r_meta_ok <= r_wr[raddr];
            if (meta_we) r_wr[meta_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_page <= n_page;
        r_fr   <= n_fr;
        r_md   <= n_md;
        r_idx  <= n_idx;
        r_vic  <= n_vic;
        r_hitf <= n_hitf;
        r_free <= n_free;
        r_kind <= n_kind;
        r_fi   <= n_fi;
        r_pn   <= n_pn;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_frame_index = r_fi;
    assign o_page_number = r_pn;
    assign o_hit         = r_hit_o;
    assign o_last        = r_last;

    `CBPM_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    `CBPM_ASSERT_SAME(a_last_idle, i_clk, i_rst_n, r_valid && r_last, r_state == S_IDLE)
    `CBPM_ASSERT_SAME(a_idle_nowr, i_clk, i_rst_n, r_state == S_IDLE, !meta_we && !tag_we)
    `CBPM_ASSERT_SAME(a_hit_reply, i_clk, i_rst_n, r_valid && r_hit_o, r_kind == K_REPLY)
endmodule
